// ----- hw/rtl/lpm_pkg.sv -----
// shared types and constants for the lidar point mask and transform core
package lpm_pkg;

  // configuration register map
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X,
    REG_POS_Y,
    REG_POS_Z,
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z,
    REG_QUAT_W
  } cfg_reg_t;

  // pose registers handed to the transform unit
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
  } xf_cfg_t;

  localparam int QUAT_ONE = 1 << 30;

  localparam xf_cfg_t CFG_RESET = '{
    pos_x:  32'sd0,
    pos_y:  32'sd0,
    pos_z:  32'sd0,
    quat_x: 32'sd0,
    quat_y: 32'sd0,
    quat_z: 32'sd0,
    quat_w: 32'sd1073741824
  };

  // fields that ride along with a point untouched
  typedef struct packed {
    logic [15:0] intensity;
    logic        last;
  } side_t;

  // mask geometry
  localparam int ONE_M   = 65536;
  localparam int Z_LIMIT = 6554;
  localparam int MASK_CW = 18;
  localparam int R2_W    = 34;
  localparam logic [R2_W-1:0] R2_OUTER = 34'd2415919104;
  localparam logic [R2_W-1:0] R2_INNER = 34'd1546188227;
  localparam int SUM_W     = 35;
  localparam int NUM_SEC   = 5;
  localparam int SEC_EDGES = 2;
  localparam int FWD_SEC   = 4;

  // cos, sin of the lower edge, then cos, sin of the upper edge, Q1.14
  typedef logic signed [15:0] sec_coef_t;
  localparam sec_coef_t SECTOR_TAB [NUM_SEC][4] = '{
    '{ 16'sd14189,  16'sd8192,   16'sd9397,   16'sd13421},
    '{-16'sd8923,   16'sd13741, -16'sd13085,  16'sd9860 },
    '{-16'sd14330, -16'sd7943,  -16'sd9162,  -16'sd13583},
    '{ 16'sd8682,  -16'sd13894,  16'sd14044, -16'sd8438 },
    '{ 16'sd15396, -16'sd5604,   16'sd15396,  16'sd5604 }
  };

  // rotation arithmetic
  localparam int PROD_W    = 35;
  localparam int MAT_W     = 36;
  localparam int MSPLIT    = 18;
  localparam int VSPLIT    = 16;
  localparam int ROT_SHIFT = 30;

  // index of the last stage before the output register
  localparam int PIPE_LAST = 9;

endpackage

// ----- hw/rtl/lpm_mask.sv -----
// near-field sector mask, two register stages
module lpm_mask import lpm_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic signed [COORD_WIDTH-1:0] z,
  output logic                          drop
);

  localparam logic signed [COORD_WIDTH-1:0] ONE_POS = COORD_WIDTH'(ONE_M);
  localparam logic signed [COORD_WIDTH-1:0] ONE_NEG = -ONE_POS;
  localparam logic signed [COORD_WIDTH-1:0] Z_LIM   = COORD_WIDTH'(Z_LIMIT);

  logic signed [MASK_CW-1:0]   xs;
  logic signed [MASK_CW-1:0]   ys;
  logic signed [2*MASK_CW-1:0] sqx;
  logic signed [2*MASK_CW-1:0] sqy;
  logic                        near_c;
  logic                        zero_c;
  logic [R2_W-1:0]             r2_c;
  logic signed [SUM_W-1:0]     sa_c [NUM_SEC];
  logic signed [SUM_W-1:0]     sb_c [NUM_SEC];

  logic                        near2;
  logic                        zero2;
  logic [R2_W-1:0]             r2_2;
  logic signed [SUM_W-1:0]     sa2 [NUM_SEC];
  logic signed [SUM_W-1:0]     sb2 [NUM_SEC];

  logic [NUM_SEC-1:0]          hit;
  logic                        side;
  logic                        fwd;
  logic                        drop_next;

  // squared range and edge cross products, only meaningful when near
  always_comb begin
    xs     = x[MASK_CW-1:0];
    ys     = y[MASK_CW-1:0];
    sqx    = xs * xs;
    sqy    = ys * ys;
    r2_c   = sqx[R2_W-1:0] + sqy[R2_W-1:0];
    near_c = (z < Z_LIM) && (x > ONE_NEG) && (x < ONE_POS) &&
             (y > ONE_NEG) && (y < ONE_POS);
    zero_c = (x == '0) && (y == '0);
    for (int k = 0; k < NUM_SEC; k++) begin
      sa_c[k] = SUM_W'(SECTOR_TAB[k][0]) * SUM_W'(ys) -
                SUM_W'(SECTOR_TAB[k][1]) * SUM_W'(xs);
      sb_c[k] = SUM_W'(SECTOR_TAB[k][3]) * SUM_W'(xs) -
                SUM_W'(SECTOR_TAB[k][2]) * SUM_W'(ys);
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      near2 <= near_c;
      zero2 <= zero_c;
      r2_2  <= r2_c;
      for (int k = 0; k < NUM_SEC; k++) begin
        sa2[k] <= sa_c[k];
        sb2[k] <= sb_c[k];
      end
    end
  end

  // sector membership and final decision
  always_comb begin
    for (int k = 0; k < NUM_SEC; k++) begin
      if (k == SEC_EDGES) begin
        hit[k] = !sa2[k][SUM_W-1] && !sb2[k][SUM_W-1];
      end else begin
        hit[k] = !sa2[k][SUM_W-1] && (sa2[k] != '0) &&
                 !sb2[k][SUM_W-1] && (sb2[k] != '0);
      end
    end
    side = |hit[FWD_SEC-1:0];
    fwd  = hit[FWD_SEC];
    // a point on the axis counts as straight ahead
    if (zero2) begin
      side = 1'b0;
      fwd  = 1'b1;
    end
    drop_next = near2 && (((r2_2 < R2_OUTER) && side) || ((r2_2 < R2_INNER) && fwd));
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      drop <= drop_next;
    end
  end

endmodule

// ----- hw/rtl/lpm_xform.sv -----
// quaternion rotation matrix and pipelined rotate, translate, saturate
module lpm_xform import lpm_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  xf_cfg_t                       cfg,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic signed [COORD_WIDTH-1:0] z,
  output logic signed [COORD_WIDTH-1:0] res_x,
  output logic signed [COORD_WIDTH-1:0] res_y,
  output logic signed [COORD_WIDTH-1:0] res_z
);

  localparam int VH_W = COORD_WIDTH - VSPLIT;
  localparam int MH_W = MAT_W - MSPLIT;
  localparam int HH_W = MH_W + VH_W;
  localparam int HL_W = MH_W + VSPLIT + 1;
  localparam int LH_W = MSPLIT + 1 + VH_W;
  localparam int LL_W = MSPLIT + 1 + VSPLIT + 1;
  localparam int PW   = MAT_W + COORD_WIDTH;
  localparam int AW   = PW + 2;
  localparam int SW   = AW - ROT_SHIFT + 1;

  localparam logic signed [MAT_W-1:0] M_ONE = MAT_W'(QUAT_ONE);
  localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  function automatic logic signed [PROD_W-1:0] twice_prod(
    input logic signed [31:0] a,
    input logic signed [31:0] b
  );
    logic signed [63:0] p;
    p = a * b;
    return p[63:63-PROD_W+1];
  endfunction

  function automatic logic signed [MAT_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    return MAT_W'(p);
  endfunction

  logic signed [PROD_W-1:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  logic signed [MAT_W-1:0]  mat [3][3];
  logic signed [MAT_W-1:0]  mat_next [3][3];

  logic signed [COORD_WIDTH-1:0] vd2 [3];
  logic signed [COORD_WIDTH-1:0] vd3 [3];

  logic signed [MH_W-1:0]     mhi [3][3];
  logic signed [MSPLIT:0]     mlo [3][3];
  logic signed [VH_W-1:0]     vhi [3];
  logic signed [VSPLIT:0]     vlo [3];

  logic signed [HH_W-1:0]     pp_hh [3][3];
  logic signed [HL_W-1:0]     pp_hl [3][3];
  logic signed [LH_W-1:0]     pp_lh [3][3];
  logic signed [LL_W-1:0]     pp_ll [3][3];
  logic signed [PW-1:0]       pa [3][3];
  logic signed [PW-1:0]       pb [3][3];
  logic signed [PW-1:0]       el [3][3];
  logic signed [AW-1:0]       t01 [3];
  logic signed [PW-1:0]       e2 [3];
  logic signed [AW-1:0]       acc [3];
  logic signed [SW-1:0]       sum9 [3];
  logic signed [31:0]         pos [3];
  logic signed [COORD_WIDTH-1:0] res [3];
  logic [SW-COORD_WIDTH:0]    upper;

  // pairwise quaternion products, twice the product in Q.30
  always_ff @(posedge clk) begin
    if (rst) begin
      pxx <= '0; pyy <= '0; pzz <= '0;
      pxy <= '0; pxz <= '0; pyz <= '0;
      pwx <= '0; pwy <= '0; pwz <= '0;
    end else begin
      pxx <= twice_prod(cfg.quat_x, cfg.quat_x);
      pyy <= twice_prod(cfg.quat_y, cfg.quat_y);
      pzz <= twice_prod(cfg.quat_z, cfg.quat_z);
      pxy <= twice_prod(cfg.quat_x, cfg.quat_y);
      pxz <= twice_prod(cfg.quat_x, cfg.quat_z);
      pyz <= twice_prod(cfg.quat_y, cfg.quat_z);
      pwx <= twice_prod(cfg.quat_w, cfg.quat_x);
      pwy <= twice_prod(cfg.quat_w, cfg.quat_y);
      pwz <= twice_prod(cfg.quat_w, cfg.quat_z);
    end
  end

  // rotation matrix from the products
  always_comb begin
    mat_next[0][0] = M_ONE - (ext(pyy) + ext(pzz));
    mat_next[0][1] = ext(pxy) - ext(pwz);
    mat_next[0][2] = ext(pxz) + ext(pwy);
    mat_next[1][0] = ext(pxy) + ext(pwz);
    mat_next[1][1] = M_ONE - (ext(pxx) + ext(pzz));
    mat_next[1][2] = ext(pyz) - ext(pwx);
    mat_next[2][0] = ext(pxz) - ext(pwy);
    mat_next[2][1] = ext(pyz) + ext(pwx);
    mat_next[2][2] = M_ONE - (ext(pxx) + ext(pyy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mat[i][j] <= (i == j) ? M_ONE : '0;
        end
      end
    end else begin
      mat <= mat_next;
    end
  end

  // coordinate delay to line up with the mask stages, vector is (y, z, x)
  always_ff @(posedge clk) begin
    if (en) begin
      vd2[0] <= y;
      vd2[1] <= z;
      vd2[2] <= x;
      vd3    <= vd2;
    end
  end

  // operand split for the partial products
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      vhi[j] = vd3[j][COORD_WIDTH-1:VSPLIT];
      vlo[j] = {1'b0, vd3[j][VSPLIT-1:0]};
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mhi[i][j] = mat[i][j][MAT_W-1:MSPLIT];
        mlo[i][j] = {1'b0, mat[i][j][MSPLIT-1:0]};
      end
    end
  end

  // stages 4 to 6: partial products, pair sums, element product
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_hh[i][j] <= mhi[i][j] * vhi[j];
          pp_hl[i][j] <= mhi[i][j] * vlo[j];
          pp_lh[i][j] <= mlo[i][j] * vhi[j];
          pp_ll[i][j] <= mlo[i][j] * vlo[j];
          pa[i][j]    <= (PW'(pp_hh[i][j]) <<< (MSPLIT + VSPLIT)) + PW'(pp_ll[i][j]);
          pb[i][j]    <= (PW'(pp_hl[i][j]) <<< MSPLIT) + (PW'(pp_lh[i][j]) <<< VSPLIT);
          el[i][j]    <= pa[i][j] + pb[i][j];
        end
      end
    end
  end

  always_comb begin
    pos[0] = cfg.pos_x;
    pos[1] = cfg.pos_y;
    pos[2] = cfg.pos_z;
  end

  // stages 7 to 9: row sum, scale back to Q16.16, translate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t01[i]  <= AW'(el[i][0]) + AW'(el[i][1]);
        e2[i]   <= el[i][2];
        acc[i]  <= t01[i] + AW'(e2[i]);
        sum9[i] <= SW'($signed(acc[i][AW-1:ROT_SHIFT])) + SW'(pos[i]);
      end
    end
  end

  // saturate to the coordinate range
  always_comb begin
    upper = '0;
    for (int i = 0; i < 3; i++) begin
      upper = sum9[i][SW-1:COORD_WIDTH-1];
      if ((&upper) || !(|upper)) begin
        res[i] = sum9[i][COORD_WIDTH-1:0];
      end else if (sum9[i][SW-1]) begin
        res[i] = SAT_MIN;
      end else begin
        res[i] = SAT_MAX;
      end
    end
  end

  assign res_x = res[0];
  assign res_y = res[1];
  assign res_z = res[2];

endmodule

// ----- hw/rtl/lidar_point_mask_and_transform_core.sv -----
// top level: lidar point crop mask with rigid transform into the map frame
//
//   channel   dir  handshake              payload
//   in        in   in_valid / in_stall    in_x, in_y, in_z, in_intensity, in_last
//   out       out  out_valid / out_stall  kept, out_x, out_y, out_z, out_intensity, out_last
//   cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one word per cycle sustained while out is not stalled; a word reaches out through the
// input register, two mask stages, six multiply and add stages and the output register
// rotation matrix follows a quaternion write through the product and matrix registers
// reset clears all valids and the skid full flag and loads the identity pose
// out_stall with out_valid high freezes every stage at once; the input side only
// sees it through a one-word skid register, so in_stall is a plain register output
module lidar_point_mask_and_transform_core import lpm_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  logic [15:0]                   in_intensity,
  input  logic                          in_last,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kept,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic [15:0]                   out_intensity,
  output logic                          out_last,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [31:0]                   cfg_data
);

  xf_cfg_t cfg;

  logic en;
  logic in_acc;

  logic                          skid_full;
  logic signed [COORD_WIDTH-1:0] skid_x, skid_y, skid_z;
  side_t                         skid_side;

  logic signed [COORD_WIDTH-1:0] s1_x, s1_y, s1_z;
  logic [PIPE_LAST:1]            vld;
  side_t                         sidep [1:PIPE_LAST];
  logic [PIPE_LAST:4]            dropp;

  logic                          drop3;
  logic signed [COORD_WIDTH-1:0] res_x, res_y, res_z;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POS_X:  cfg.pos_x  <= cfg_data;
        REG_POS_Y:  cfg.pos_y  <= cfg_data;
        REG_POS_Z:  cfg.pos_z  <= cfg_data;
        REG_QUAT_X: cfg.quat_x <= cfg_data;
        REG_QUAT_Y: cfg.quat_y <= cfg_data;
        REG_QUAT_Z: cfg.quat_z <= cfg_data;
        REG_QUAT_W: cfg.quat_w <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance and input acceptance
  assign en       = !out_valid || !out_stall;
  assign in_stall = skid_full;
  assign in_acc   = in_valid && !skid_full;

  // valid bits and skid state
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (en) begin
      vld       <= {vld[PIPE_LAST-1:1], skid_full || in_acc};
      out_valid <= vld[PIPE_LAST];
      skid_full <= 1'b0;
    end else if (in_acc) begin
      skid_full <= 1'b1;
    end
  end

  // skid register catches a word taken while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (!en && in_acc) begin
      skid_x    <= in_x;
      skid_y    <= in_y;
      skid_z    <= in_z;
      skid_side <= '{intensity: in_intensity, last: in_last};
    end
  end

  // stage 1 load, side fields and drop flag shift lines, output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (skid_full) begin
        s1_x     <= skid_x;
        s1_y     <= skid_y;
        s1_z     <= skid_z;
        sidep[1] <= skid_side;
      end else begin
        s1_x     <= in_x;
        s1_y     <= in_y;
        s1_z     <= in_z;
        sidep[1] <= '{intensity: in_intensity, last: in_last};
      end
      for (int k = 2; k <= PIPE_LAST; k++) begin
        sidep[k] <= sidep[k-1];
      end
      dropp <= {dropp[PIPE_LAST-1:4], drop3};
      kept          <= !dropp[PIPE_LAST];
      out_x         <= dropp[PIPE_LAST] ? '0 : res_x;
      out_y         <= dropp[PIPE_LAST] ? '0 : res_y;
      out_z         <= dropp[PIPE_LAST] ? '0 : res_z;
      out_intensity <= sidep[PIPE_LAST].intensity;
      out_last      <= sidep[PIPE_LAST].last;
    end
  end

  lpm_mask #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mask (
    .clk  (clk),
    .en   (en),
    .x    (s1_x),
    .y    (s1_y),
    .z    (s1_z),
    .drop (drop3)
  );

  lpm_xform #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_xform (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .cfg   (cfg),
    .x     (s1_x),
    .y     (s1_y),
    .z     (s1_z),
    .res_x (res_x),
    .res_y (res_y),
    .res_z (res_z)
  );

  // skid register empties on the first cycle the pipeline moves
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_full && en |=> !skid_full)
    else $error("skid register held a word across an advancing cycle");

  // skid only fills when a word arrives into a frozen pipeline
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(!en) && $past(in_valid))
    else $error("skid register filled without a frozen pipeline");

  // a frozen pipeline keeps its occupancy
  a_frozen_valids: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valids moved while the output was stalled");

  // a dropped point carries zero coordinates
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kept |-> (out_x == '0) && (out_y == '0) && (out_z == '0))
    else $error("dropped word carries nonzero coordinates");

endmodule
